[sv/tss_pkg.sv]
package tss_pkg;

  localparam int unsigned TDATA_W = 104;

  localparam logic KIND_DESC    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] section_type;
    logic [15:0] section_length;
    logic [31:0] body_offset;
    logic [15:0] section_index;
    logic [15:0] total_sections;
    logic        parse_status;
    logic        run_end;
  } result_t;

  typedef struct packed {
    logic push_first;
    logic push_second;
  } push_ctl_t;

endpackage

[sv/tss_fifo.sv]
module tss_fifo (
  input  logic              clk,
  input  logic              rst,
  input  tss_pkg::push_ctl_t push,
  input  tss_pkg::result_t  din0,
  input  tss_pkg::result_t  din1,
  input  logic              pop,
  output tss_pkg::result_t  dout,
  output logic              not_empty,
  output logic              room_two
);
  import tss_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  result_t         entry [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic [AW-1:0]   wr_ptr_next;
  logic [AW:0]     count_next;
  logic [AW:0]     push_n;
  logic            do_pop;

  assign do_pop    = pop && not_empty;
  assign not_empty = (count != '0);
  assign room_two  = (count <= (AW+1)'(DEPTH - 2));
  assign dout      = entry[rd_ptr];

  // second entry is only written when the first one is
  always_comb begin
    push_n = (AW+1)'(push.push_first) + (AW+1)'(push.push_second);
    wr_ptr_next = wr_ptr + push_n[AW-1:0];
    count_next  = count + push_n - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.push_first) begin
      entry[wr_ptr] <= din0;
    end
    if (push.push_second) begin
      entry[wr_ptr + AW'(1)] <= din1;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
    end
  end

endmodule

[sv/tlv_section_splitter.sv]
// tlv section splitter
// takes one payload byte per transfer on the s_ channel, s_tlast on the final
// byte. each section is a big-endian 16-bit type, a 16-bit length and that many
// body bytes. when a body completes, a descriptor is emitted on the m_ channel
// (m_tuser = 0); the payload's last byte also emits a summary (m_tuser = 1)
// with the section count and an overrun flag, after any descriptor that byte
// completes. m_tlast marks the last result caused by one input byte.
// once max_sections sections are found, the rest of the payload is ignored.
// a result is written to the output fifo when its byte transfers and is shown on m_ from there.
// throughput: one byte per cycle while s_tready is high; results queue in a
// four-entry output fifo, and s_tready stays high while two entries are free,
// so a stalled receiver backs up into s_tready once three entries are occupied.
// a last byte that closes a section yields two results.
// reset clears the parser and the fifo and sets max_sections to 16; the parser
// also returns to its start state after each last byte. cfg_we writes
// max_sections; write it only while the block is idle.
module tlv_section_splitter (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [15:0]               cfg_wdata,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,   // [7:0] data_byte
  input  logic                      s_tlast,   // is_last
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [tss_pkg::TDATA_W-1:0] m_tdata, // [15:0] section_type,
                                               // [31:16] section_length,
                                               // [63:32] body_offset,
                                               // [79:64] section_index,
                                               // [95:80] total_sections,
                                               // [96] parse_status, rest zero
  output logic                      m_tuser,   // [0] item_kind
  output logic                      m_tlast    // run_end
);
  import tss_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_BODY, PH_STOP
  } phase_t;

  logic [15:0] max_sections;
  phase_t      phase;
  logic [23:0] header_hold;
  logic [15:0] body_left;
  logic [31:0] byte_offset;
  logic [31:0] body_start;
  logic [15:0] found_count;

  phase_t      phase_next;
  logic [23:0] header_hold_next;
  logic [15:0] body_left_next;
  logic [31:0] body_start_next;
  logic [15:0] found_count_next;
  phase_t      ph;
  logic        done;
  logic [15:0] dtype;
  logic [15:0] dlen;
  logic        accept;

  result_t   desc;
  result_t   summ;
  result_t   din0;
  push_ctl_t push;
  result_t   dout;
  logic      room_two;

  assign accept = s_tvalid && s_tready;

  always_comb begin
    phase_next       = phase;
    header_hold_next = header_hold;
    body_left_next   = body_left;
    body_start_next  = body_start;
    done  = 1'b0;
    dtype = '0;
    dlen  = '0;

    ph = phase;
    if (phase == PH_HDR0 && found_count >= max_sections) begin
      ph = PH_STOP;
    end
    phase_next = ph;

    if (ph < PH_HDR3) begin
      header_hold_next = {header_hold[15:0], s_tdata};
      phase_next       = phase_t'(ph + 3'd1);
    end else if (ph == PH_HDR3) begin
      dtype           = header_hold[23:8];
      dlen            = {header_hold[7:0], s_tdata};
      body_start_next = byte_offset + 32'd1;
      if (dlen == '0) begin
        done             = 1'b1;
        phase_next       = PH_HDR0;
        header_hold_next = '0;
      end else begin
        header_hold_next = {8'd0, dtype};
        body_left_next   = dlen;
        phase_next       = PH_BODY;
      end
    end else if (ph == PH_BODY) begin
      body_left_next = body_left - 16'd1;
      if (body_left_next == '0) begin
        dtype            = header_hold[15:0];
        dlen             = byte_offset[15:0] + 16'd1 - body_start[15:0];
        done             = 1'b1;
        phase_next       = PH_HDR0;
        header_hold_next = '0;
      end
    end

    found_count_next = found_count + 16'(done);

    desc                = '0;
    desc.item_kind      = KIND_DESC;
    desc.section_type   = dtype;
    desc.section_length = dlen;
    desc.body_offset    = body_start_next;
    desc.section_index  = found_count;
    desc.run_end        = !s_tlast;

    // an open body is never at zero bytes left, so body phase means overrun
    summ                = '0;
    summ.item_kind      = KIND_SUMMARY;
    summ.total_sections = found_count_next;
    summ.parse_status   = (phase_next == PH_BODY);
    summ.run_end        = 1'b1;

    din0              = done ? desc : summ;
    push.push_first   = accept && (done || s_tlast);
    push.push_second  = accept && done && s_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_sections <= 16'd16;
      phase        <= PH_HDR0;
      header_hold  <= '0;
      body_left    <= '0;
      byte_offset  <= '0;
      body_start   <= '0;
      found_count  <= '0;
    end else begin
      if (cfg_we) begin
        max_sections <= cfg_wdata;
      end
      if (accept) begin
        if (s_tlast) begin
          phase       <= PH_HDR0;
          header_hold <= '0;
          body_left   <= '0;
          byte_offset <= '0;
          body_start  <= '0;
          found_count <= '0;
        end else begin
          phase       <= phase_next;
          header_hold <= header_hold_next;
          body_left   <= body_left_next;
          byte_offset <= byte_offset + 32'd1;
          body_start  <= body_start_next;
          found_count <= found_count_next;
        end
      end
    end
  end

  tss_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din0      (din0),
    .din1      (summ),
    .pop       (m_tready),
    .dout      (dout),
    .not_empty (m_tvalid),
    .room_two  (room_two)
  );

  assign s_tready = room_two;
  assign m_tuser  = dout.item_kind;
  assign m_tlast  = dout.run_end;
  assign m_tdata  = {7'd0, dout.parse_status, dout.total_sections, dout.section_index,
                     dout.body_offset, dout.section_length, dout.section_type};

endmodule

[test/tlv_section_splitter_tb.sv]
module tlv_section_splitter_tb;
  import tss_pkg::*;

  localparam int STALL_LIMIT = 3000;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_BODY, PH_STOP
  } parse_phase_e;

  typedef struct packed {
    logic       drain;   // hold this byte back until all results are in
    logic       eop;
    logic [7:0] data;
  } byte_item_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [15:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b1;
  logic [TDATA_W-1:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  tlv_section_splitter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  byte_item_t byte_queue[$];
  result_t    due_results[$];

  // parser copy
  logic [15:0]  section_cap = 16'd16;
  parse_phase_e ph = PH_HDR0;
  logic [23:0]  hdr_hold = '0;
  logic [15:0]  body_left = '0;
  logic [31:0]  byte_off = '0;
  logic [31:0]  body_start = '0;
  logic [15:0]  found = '0;

  int fail_count = 0;
  int bytes_accepted = 0;
  int descriptors_seen = 0;
  int summaries_seen = 0;
  int overruns_seen = 0;
  int settings_used = 1;

  task automatic parse_byte(input logic [7:0] b, input logic eop);
    result_t     desc;
    result_t     summ;
    logic [15:0] dtype;
    logic [15:0] dlen;
    logic [31:0] span;
    bit          done;
    done = 1'b0;
    dtype = '0;
    dlen = '0;
    if (ph == PH_HDR0 && found >= section_cap) ph = PH_STOP;
    case (ph)
      PH_HDR0, PH_HDR1, PH_HDR2: begin
        hdr_hold = {hdr_hold[15:0], b};
        ph = parse_phase_e'(ph + 3'd1);
      end
      PH_HDR3: begin
        dtype = hdr_hold[23:8];
        dlen = {hdr_hold[7:0], b};
        body_start = byte_off + 32'd1;
        if (dlen == 16'd0) begin
          done = 1'b1;
          ph = PH_HDR0;
          hdr_hold = '0;
        end else begin
          hdr_hold = {8'h00, dtype};
          body_left = dlen;
          ph = PH_BODY;
        end
      end
      PH_BODY: begin
        body_left = body_left - 16'd1;
        if (body_left == 16'd0) begin
          dtype = hdr_hold[15:0];
          span = byte_off + 32'd1 - body_start;
          dlen = span[15:0];
          done = 1'b1;
          ph = PH_HDR0;
          hdr_hold = '0;
        end
      end
      default: ;
    endcase
    if (done) begin
      desc = '0;
      desc.item_kind = KIND_DESC;
      desc.section_type = dtype;
      desc.section_length = dlen;
      desc.body_offset = body_start;
      desc.section_index = found;
      desc.run_end = !eop;
      due_results.push_back(desc);
      found = found + 16'd1;
    end
    byte_off = byte_off + 32'd1;
    if (eop) begin
      summ = '0;
      summ.item_kind = KIND_SUMMARY;
      summ.total_sections = found;
      summ.parse_status = (ph == PH_BODY && body_left != 16'd0);
      summ.run_end = 1'b1;
      due_results.push_back(summ);
      ph = PH_HDR0;
      hdr_hold = '0;
      body_left = '0;
      byte_off = '0;
      body_start = '0;
      found = '0;
    end
  endtask

  // sender: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, s_tlast);
        bytes_accepted++;
        void'(byte_queue.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        // hold the offered byte
      end else if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left--;
      end else if (byte_queue.size() == 0 ||
                   (byte_queue[0].drain && due_results.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata <= byte_queue[0].data;
        s_tlast <= byte_queue[0].eop;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 20);
          gap_left = $urandom_range(0, 8);
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // receiver: switches between always ready, random and long stalls
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_hold = 0;

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        $error("result transfer with nothing expected: tuser %0h tdata %0h",
               m_tuser, m_tdata);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("item_kind", want.item_kind, m_tuser);
        check_field("section_type", want.section_type, m_tdata[15:0]);
        check_field("section_length", want.section_length, m_tdata[31:16]);
        check_field("body_offset", want.body_offset, m_tdata[63:32]);
        check_field("section_index", want.section_index, m_tdata[79:64]);
        check_field("total_sections", want.total_sections, m_tdata[95:80]);
        check_field("parse_status", want.parse_status, m_tdata[96]);
        check_field("tdata padding", '0, m_tdata[TDATA_W-1:97]);
        check_field("run_end", want.run_end, m_tlast);
      end
      if (m_tuser == KIND_SUMMARY) begin
        summaries_seen++;
        if (m_tdata[96]) overruns_seen++;
      end else begin
        descriptors_seen++;
      end
    end
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(20, 150);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_hold > 0) begin
          m_tready <= 1'b0;
          rx_hold--;
        end else begin
          m_tready <= 1'b1;
          if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 16);
        end
      end
    endcase
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic push_byte(input logic [7:0] data, input logic eop,
                           input logic drain = 1'b0);
    byte_item_t it;
    it.data = data;
    it.eop = eop;
    it.drain = drain;
    byte_queue.push_back(it);
  endtask

  task automatic wait_idle();
    while (byte_queue.size() != 0 || s_tvalid || due_results.size() != 0)
      @(posedge clk);
    // a byte that yields no result may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [15:0] cap);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    section_cap = cap;
    settings_used++;
  endtask

  task automatic queue_random_payload(output int n);
    logic [7:0] payload[$];
    int         nsec;
    int         len;
    int         k;
    int         ending;
    logic [15:0] stype;
    nsec = $urandom_range(0, 5);
    for (int s = 0; s < nsec; s++) begin
      stype = 16'($urandom);
      k = $urandom_range(0, 99);
      if (k < 10) len = 0;
      else if (k < 96) len = $urandom_range(1, 12);
      else len = $urandom_range(256, 300);
      payload.push_back(stype[15:8]);
      payload.push_back(stype[7:0]);
      payload.push_back(len[15:8]);
      payload.push_back(len[7:0]);
      for (int i = 0; i < len; i++) payload.push_back(8'($urandom));
    end
    ending = $urandom_range(0, 9);
    if (ending == 5) begin
      // trailing partial header
      repeat ($urandom_range(1, 3)) payload.push_back(8'($urandom));
    end else if (ending == 6 || ending == 7) begin
      // body cut short by the end of the payload
      stype = 16'($urandom);
      len = $urandom_range(1, 65535);
      payload.push_back(stype[15:8]);
      payload.push_back(stype[7:0]);
      payload.push_back(len[15:8]);
      payload.push_back(len[7:0]);
      k = (len > 6) ? $urandom_range(0, 6) : $urandom_range(0, len - 1);
      repeat (k) payload.push_back(8'($urandom));
    end else if (ending == 8) begin
      repeat ($urandom_range(1, 6)) payload.push_back(8'($urandom));
    end
    if (payload.size() == 0) payload.push_back(8'($urandom));
    n = payload.size();
    for (int i = 0; i < n; i++)
      push_byte(payload[i], i == n - 1, i == 0 && $urandom_range(0, 7) == 0);
  endtask

  initial begin
    int random_bytes;
    int n;
    int phase_no;
    int npay;
    logic [15:0] cap;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset capacity: zero-length body, short bodies, last byte closes a section
    push_byte(8'hFF, 0); push_byte(8'hFF, 0); push_byte(8'h00, 0); push_byte(8'h00, 0);
    push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h01, 0);
    push_byte(8'hA5, 0);
    push_byte(8'h80, 0); push_byte(8'h01, 0); push_byte(8'h00, 0); push_byte(8'h03, 0);
    push_byte(8'h00, 0); push_byte(8'hFF, 0); push_byte(8'h5A, 1);
    // single-byte payload, a trailing partial header; sender drains first
    push_byte(8'h7E, 1, 1);
    // body overruns the payload
    push_byte(8'h12, 0); push_byte(8'h34, 0); push_byte(8'hFF, 0); push_byte(8'hFF, 0);
    push_byte(8'h11, 0); push_byte(8'h22, 1);
    // zero-length section closed by the last byte
    push_byte(8'hAB, 0); push_byte(8'hCD, 0); push_byte(8'h00, 0); push_byte(8'h00, 1);

    // capacity zero: everything ignored
    set_capacity(16'd0);
    push_byte(8'h55, 0); push_byte(8'hAA, 0); push_byte(8'h00, 0); push_byte(8'h00, 1);

    // capacity one: second section ignored, last byte in stopped state
    set_capacity(16'd1);
    push_byte(8'h00, 0); push_byte(8'h01, 0); push_byte(8'h00, 0); push_byte(8'h00, 0);
    push_byte(8'h00, 0); push_byte(8'h02, 0); push_byte(8'h00, 0); push_byte(8'h01, 0);
    push_byte(8'hEE, 1);

    random_bytes = 0;
    phase_no = 0;
    while (random_bytes < 950) begin
      case (phase_no % 6)
        0: cap = 16'hFFFF;
        1: cap = 16'd1;
        2: cap = 16'($urandom_range(2, 4));
        3: cap = 16'd0;
        4: cap = 16'd16;
        default: cap = 16'($urandom);
      endcase
      set_capacity(cap);
      npay = (cap == 16'd0) ? 2 : $urandom_range(3, 8);
      repeat (npay) begin
        queue_random_payload(n);
        if (cap != 16'd0) random_bytes += n;
      end
      phase_no++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("run covered %0d payload bytes under %0d capacity settings", bytes_accepted,
             settings_used);
    $display("checked %0d section descriptors and %0d summaries, %0d with overrun",
             descriptors_seen, summaries_seen, overruns_seen);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
